// ===== rtl/core/fpma_pkg.sv =====
// ----------------------------------------------------------------------------
// fpma_pkg
// Shared types, constants and the control store of the flow period meter.
// ----------------------------------------------------------------------------
package fpma_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned HALF_W = 16;
	localparam int unsigned STEP_W = 4;
	localparam int unsigned CNT_W  = 6;

	localparam logic [CNT_W-1:0]  DIV_ITERS   = CNT_W'(DATA_W);
	localparam logic [DATA_W-1:0] FLOW_NUM_Q8 = 32'd3840000000;
	localparam logic [HALF_W-1:0] WEIGHT_NUM  = 16'hFFFF;

	localparam logic [HALF_W-1:0] PPL_RST  = 16'd450;
	localparam logic [HALF_W-1:0] MAXS_RST = 16'd32;
	localparam logic [HALF_W-1:0] SBY_RST  = 16'd100;

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_CAPTURE  = 2'd1,
		REQ_OVERFLOW = 2'd2,
		REQ_UNUSED   = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_PPL  = 2'd0,
		CFG_MAXS = 2'd1,
		CFG_SBY  = 2'd2,
		CFG_NONE = 2'd3
	} cfg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP      = 4'd0,
		OP_CNT      = 4'd1,
		OP_MUL      = 4'd2,
		OP_LD_FLOW  = 4'd3,
		OP_DIV      = 4'd4,
		OP_ST_FLOW  = 4'd5,
		OP_LD_WT    = 4'd6,
		OP_ST_WT    = 4'd7,
		OP_LD_STEP  = 4'd8,
		OP_ST_MEAN  = 4'd9,
		OP_SIMPLE   = 4'd10,
		OP_ZERR     = 4'd11,
		OP_EMIT     = 4'd12
	} op_t;

	typedef enum logic [2:0] {
		C_NEXT     = 3'd0,
		C_ALWAYS   = 3'd1,
		C_NO_REQ   = 3'd2,
		C_NOT_CAP  = 3'd3,
		C_ZERO     = 3'd4,
		C_DIV_BUSY = 3'd5,
		C_OUT_FULL = 3'd6
	} cond_t;

	typedef logic [STEP_W-1:0] step_t;

	// program addresses
	localparam step_t A_IDLE     = 4'd0;
	localparam step_t A_COUNTS   = 4'd1;
	localparam step_t A_MUL      = 4'd2;
	localparam step_t A_LD_FLOW  = 4'd3;
	localparam step_t A_DIV_FLOW = 4'd4;
	localparam step_t A_ST_FLOW  = 4'd5;
	localparam step_t A_LD_WT    = 4'd6;
	localparam step_t A_DIV_WT   = 4'd7;
	localparam step_t A_ST_WT    = 4'd8;
	localparam step_t A_LD_STEP  = 4'd9;
	localparam step_t A_DIV_STEP = 4'd10;
	localparam step_t A_ST_MEAN  = 4'd11;
	localparam step_t A_SPARE    = 4'd12;
	localparam step_t A_SIMPLE   = 4'd13;
	localparam step_t A_ZERR     = 4'd14;
	localparam step_t A_EMIT     = 4'd15;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ctl_word_t;

	typedef struct packed {
		logic no_req;
		logic not_cap;
		logic zero;
		logic div_busy;
		logic out_full;
	} cond_in_t;

	typedef struct packed {
		logic [HALF_W-1:0] ppl;
		logic [HALF_W-1:0] max_samples;
		logic [HALF_W-1:0] standby_ticks;
	} cfg_t;

	typedef struct packed {
		logic [DATA_W-1:0] mean;
		logic              start;
		logic              updated;
		logic              zerr;
		logic              measuring;
	} res_t;

	typedef struct packed {
		logic [1:0]        req;
		logic [HALF_W-1:0] first;
		logic [HALF_W-1:0] second;
	} item_t;

	function automatic ctl_word_t ctl_rom(input step_t addr);
		ctl_word_t w;
		unique case (addr)
			A_IDLE:     w = '{OP_NOP,     C_NO_REQ,   A_IDLE};
			A_COUNTS:   w = '{OP_CNT,     C_NOT_CAP,  A_SIMPLE};
			A_MUL:      w = '{OP_MUL,     C_ZERO,     A_ZERR};
			A_LD_FLOW:  w = '{OP_LD_FLOW, C_NEXT,     A_IDLE};
			A_DIV_FLOW: w = '{OP_DIV,     C_DIV_BUSY, A_DIV_FLOW};
			A_ST_FLOW:  w = '{OP_ST_FLOW, C_NEXT,     A_IDLE};
			A_LD_WT:    w = '{OP_LD_WT,   C_NEXT,     A_IDLE};
			A_DIV_WT:   w = '{OP_DIV,     C_DIV_BUSY, A_DIV_WT};
			A_ST_WT:    w = '{OP_ST_WT,   C_NEXT,     A_IDLE};
			A_LD_STEP:  w = '{OP_LD_STEP, C_NEXT,     A_IDLE};
			A_DIV_STEP: w = '{OP_DIV,     C_DIV_BUSY, A_DIV_STEP};
			A_ST_MEAN:  w = '{OP_ST_MEAN, C_ALWAYS,   A_EMIT};
			A_SPARE:    w = '{OP_NOP,     C_ALWAYS,   A_IDLE};
			A_SIMPLE:   w = '{OP_SIMPLE,  C_ALWAYS,   A_EMIT};
			A_ZERR:     w = '{OP_ZERR,    C_NEXT,     A_IDLE};
			A_EMIT:     w = '{OP_EMIT,    C_OUT_FULL, A_EMIT};
			default:    w = '{OP_NOP,     C_ALWAYS,   A_IDLE};
		endcase
		return w;
	endfunction

endpackage

// ===== rtl/core/fpma_item_if.sv =====
// ----------------------------------------------------------------------------
// fpma_item_if
// Request channel of the flow period meter: tick, capture pair or overflow.
// ----------------------------------------------------------------------------
interface fpma_item_if import fpma_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        req_type;
	logic [HALF_W-1:0] first_capture;
	logic [HALF_W-1:0] second_capture;

	modport source (output valid, output req_type, output first_capture,
		output second_capture, input ready);
	modport sink (input valid, input req_type, input first_capture,
		input second_capture, output ready);
endinterface

// ===== rtl/core/fpma_result_if.sv =====
// ----------------------------------------------------------------------------
// fpma_result_if
// Result channel of the flow period meter: filtered flow and status flags.
// ----------------------------------------------------------------------------
interface fpma_result_if import fpma_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] flow_mean_q8;
	logic              start_capture;
	logic              mean_updated;
	logic              zero_period_error;
	logic              measuring;

	modport source (output valid, output flow_mean_q8, output start_capture,
		output mean_updated, output zero_period_error, output measuring, input ready);
	modport sink (input valid, input flow_mean_q8, input start_capture,
		input mean_updated, input zero_period_error, input measuring, output ready);
endinterface

// ===== rtl/core/fpma_div.sv =====
// ----------------------------------------------------------------------------
// fpma_div
// Restoring unsigned divider, one quotient bit per cycle while run is high.
// ----------------------------------------------------------------------------
module fpma_div import fpma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic              run,
	input  logic [DATA_W-1:0] dvd,
	input  logic [DATA_W-1:0] dvs,
	output logic [DATA_W-1:0] quo,
	output logic              last
);

	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   trial;
	logic              ge;

	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign trial   = shifted - {1'b0, dvs_q};
	assign ge      = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= DIV_ITERS;
		end else if (run && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= dvd;
			rem_q <= '0;
			dvs_q <= dvs;
		end else if (run) begin
			quo_q <= {quo_q[DATA_W-2:0], ge};
			rem_q <= ge ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
		end
	end

	assign quo  = quo_q;
	assign last = cnt_q == CNT_W'(1);

endmodule

// ===== rtl/core/fpma_seq.sv =====
// ----------------------------------------------------------------------------
// fpma_seq
// Step counter and control store; picks the next step from the jump condition.
// ----------------------------------------------------------------------------
module fpma_seq import fpma_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cond_in_t cin,
	output op_t      op,
	output logic     idle
);

	step_t     step_q;
	step_t     step_nxt;
	ctl_word_t word;
	logic      take;

	assign word = ctl_rom(step_q);

	always_comb begin
		unique case (word.cond)
			C_NEXT:     take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_REQ:   take = cin.no_req;
			C_NOT_CAP:  take = cin.not_cap;
			C_ZERO:     take = cin.zero;
			C_DIV_BUSY: take = cin.div_busy;
			C_OUT_FULL: take = cin.out_full;
			default:    take = 1'b0;
		endcase
		// last step wraps to idle on fall-through
		step_nxt = take ? word.target : step_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= A_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	assign op   = word.op;
	assign idle = step_q == A_IDLE;

endmodule

// ===== rtl/core/fpma_dp.sv =====
// ----------------------------------------------------------------------------
// fpma_dp
// Datapath: mode state, period arithmetic and the running mean.
// ----------------------------------------------------------------------------
module fpma_dp import fpma_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  op_t   op,
	input  logic  take,
	input  item_t item,
	input  cfg_t  cfg,
	output logic  not_cap,
	output logic  zero,
	output logic  div_busy,
	output res_t  res
);

	logic [1:0]        req_q;
	logic [HALF_W-1:0] c1_q;
	logic [HALF_W-1:0] c2_q;
	logic [HALF_W-1:0] counts_q;
	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] flow_q;
	logic [HALF_W-1:0] weight_q;
	logic              neg_q;
	logic [DATA_W-1:0] mag_q;
	logic [DATA_W-1:0] mean_q;
	logic              mode_q;
	logic              pend_q;
	logic [HALF_W-1:0] sby_q;
	logic              start_q;
	logic              upd_q;
	logic              zerr_q;

	logic [HALF_W-1:0] ppl_eff;
	logic [HALF_W-1:0] cap_eff;
	logic [HALF_W-1:0] wt_raw;
	logic [DATA_W:0]   diff;
	logic [DATA_W-1:0] quo;
	logic              last;
	logic              div_load;
	logic [DATA_W-1:0] dvd;
	logic [DATA_W-1:0] dvs;

	assign ppl_eff = (cfg.ppl == '0) ? HALF_W'(1) : cfg.ppl;
	assign cap_eff = (cfg.max_samples == '0) ? HALF_W'(1) : cfg.max_samples;
	assign wt_raw  = quo[HALF_W-1:0];
	assign diff    = {1'b0, flow_q} - {1'b0, mean_q};

	always_comb begin
		div_load = 1'b1;
		unique case (op)
			OP_LD_FLOW: begin
				dvd = FLOW_NUM_Q8;
				dvs = prod_q;
			end
			OP_LD_WT: begin
				dvd = {{HALF_W{1'b0}}, WEIGHT_NUM};
				dvs = {{HALF_W{1'b0}}, counts_q};
			end
			OP_LD_STEP: begin
				dvd = mag_q;
				dvs = {{HALF_W{1'b0}}, weight_q};
			end
			default: begin
				div_load = 1'b0;
				dvd      = mag_q;
				dvs      = prod_q;
			end
		endcase
	end

	fpma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (div_load),
		.run    (op == OP_DIV),
		.dvd    (dvd),
		.dvs    (dvs),
		.quo    (quo),
		.last   (last)
	);

	// item latch and arithmetic scratch
	always_ff @(posedge clk) begin
		if (take) begin
			req_q <= item.req;
			c1_q  <= item.first;
			c2_q  <= item.second;
		end
		unique case (op)
			OP_CNT:     counts_q <= c2_q - c1_q;
			OP_MUL:     prod_q   <= DATA_W'(counts_q) * DATA_W'(ppl_eff);
			OP_ST_FLOW: flow_q   <= quo;
			OP_ST_WT: begin
				// quotient of 65535 by a 16-bit count never exceeds 16 bits or drops to 0
				weight_q <= (wt_raw > cap_eff) ? cap_eff : wt_raw;
				neg_q    <= diff[DATA_W];
				mag_q    <= diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= '0;
			mode_q  <= 1'b0;
			pend_q  <= 1'b0;
			sby_q   <= SBY_RST;
			start_q <= 1'b0;
			upd_q   <= 1'b0;
			zerr_q  <= 1'b0;
		end else begin
			unique case (op)
				OP_CNT: begin
					start_q <= 1'b0;
					upd_q   <= 1'b0;
					zerr_q  <= 1'b0;
				end
				OP_SIMPLE: begin
					priority if (req_q == REQ_TICK) begin
						if (!mode_q) begin
							if (sby_q == '0) begin
								mode_q <= 1'b1;
							end else begin
								sby_q <= sby_q - 1'b1;
							end
						end else if (!pend_q) begin
							pend_q  <= 1'b1;
							start_q <= 1'b1;
						end
					end else if (req_q == REQ_OVERFLOW && mode_q && pend_q) begin
						mean_q <= '0;
						upd_q  <= 1'b1;
						mode_q <= 1'b0;
						pend_q <= 1'b0;
						sby_q  <= cfg.standby_ticks;
					end else begin
					end
				end
				OP_ZERR: begin
					zerr_q <= 1'b1;
					mode_q <= 1'b0;
					pend_q <= 1'b0;
					sby_q  <= cfg.standby_ticks;
				end
				OP_ST_MEAN: begin
					// step truncates toward zero, so the mean stays between old value and flow
					mean_q <= neg_q ? mean_q - quo : mean_q + quo;
					upd_q  <= 1'b1;
					mode_q <= 1'b0;
					pend_q <= 1'b0;
					sby_q  <= cfg.standby_ticks;
				end
				default: ;
			endcase
		end
	end

	assign not_cap  = !(req_q == REQ_CAPTURE && mode_q && pend_q);
	assign zero     = counts_q == '0;
	assign div_busy = !last;

	assign res.mean      = mean_q;
	assign res.start     = start_q;
	assign res.updated   = upd_q;
	assign res.zerr      = zerr_q;
	assign res.measuring = mode_q;

endmodule

// ===== rtl/core/flow_period_meter_averaging.sv =====
// ----------------------------------------------------------------------------
// flow_period_meter_averaging
// Pulse period flow meter with standby delay and adaptive running mean.
// ----------------------------------------------------------------------------
// Requests arrive on the item channel (valid/ready): a tick, a capture pair or
// a timer overflow. Every request gives exactly one result on the result
// channel: the running mean in Q24.8 with the mode and status flags.
// Registers are written through cfg_wr_en/cfg_index/cfg_wdata; index 0 pulses
// per litre, 1 max samples, 2 standby ticks. The user must write them only
// while the block is idle; the block does not enforce it. A microcoded
// sequencer steps a small datapath. A tick, an overflow or an ignored request
// uses no divider pass. A capture that is measured goes through three passes
// of one shared bit-serial divider (flow, weight, mean step); a zero period
// goes to the error step. A new request is accepted once the sequencer is
// back at idle. The result sits in an output register, so the next request
// may be taken while it waits; if the receiver stalls and the slot is still
// full when the next result is ready, the sequencer holds at its last step.
// Reset (arst_n low) clears the mode to standby, the mean to zero, loads the
// register defaults and empties the output register.
// ----------------------------------------------------------------------------
module flow_period_meter_averaging import fpma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fpma_item_if.sink         item,
	fpma_result_if.source     result,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_index,
	input  logic [HALF_W-1:0] cfg_wdata
);

	cfg_t     cfg_q;
	res_t     res;
	res_t     res_q;
	logic     out_valid_q;
	logic     out_full;
	op_t      op;
	logic     idle;
	logic     take;
	logic     not_cap;
	logic     zero;
	logic     div_busy;
	cond_in_t cin;
	item_t    item_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ppl           <= PPL_RST;
			cfg_q.max_samples   <= MAXS_RST;
			cfg_q.standby_ticks <= SBY_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_PPL:  cfg_q.ppl           <= cfg_wdata;
				CFG_MAXS: cfg_q.max_samples   <= cfg_wdata;
				CFG_SBY:  cfg_q.standby_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign item.ready      = idle;
	assign take            = item.valid && idle;
	assign item_in.req     = item.req_type;
	assign item_in.first   = item.first_capture;
	assign item_in.second  = item.second_capture;
	assign out_full        = out_valid_q && !result.ready;

	assign cin.no_req   = !item.valid;
	assign cin.not_cap  = not_cap;
	assign cin.zero     = zero;
	assign cin.div_busy = div_busy;
	assign cin.out_full = out_full;

	fpma_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cin    (cin),
		.op     (op),
		.idle   (idle)
	);

	fpma_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.take     (take),
		.item     (item_in),
		.cfg      (cfg_q),
		.not_cap  (not_cap),
		.zero     (zero),
		.div_busy (div_busy),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_EMIT && !out_full) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == OP_EMIT && !out_full) begin
			res_q <= res;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.flow_mean_q8      = res_q.mean;
	assign result.start_capture     = res_q.start;
	assign result.mean_updated      = res_q.updated;
	assign result.zero_period_error = res_q.zerr;
	assign result.measuring         = res_q.measuring;

endmodule
